[hw/rtl/euler_zyx_to_quaternion_top_defines.svh]
// ----------------------------------------------------------------------------
// Euler ZYX to quaternion: assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef EULER_ZYX_TO_QUATERNION_TOP_DEFINES_SVH
`define EULER_ZYX_TO_QUATERNION_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define EZQ_AST_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ezq assertion failed");

// next-cycle implication, off during reset
`define EZQ_AST_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ezq assertion failed");

// next-cycle implication, always on (used for reset behavior)
`define EZQ_AST_NEXT_ALL(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ezq reset assertion failed");

`endif

[hw/rtl/ezq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezq_pkg
// Widths, constants, types and the arctangent table of the Euler converter.
// ----------------------------------------------------------------------------
package ezq_pkg;

  localparam int OUT_WIDTH  = 16;
  localparam int TRIG_STEPS = 16;
  localparam int ANG_W      = 17;
  localparam int TABLE_LEN  = 32;
  localparam int CORDIC_N   = (TRIG_STEPS > TABLE_LEN) ? TABLE_LEN : TRIG_STEPS;

  localparam int XW  = 33;          // CORDIC x/y, Q30 plus headroom
  localparam int ZW  = 26;          // angle, 2^-16 degree
  localparam int PW  = 2 * XW;      // first product, Q60
  localparam int ABW = 34;          // first product rounded to Q30
  localparam int TW  = ABW + XW;    // triple product, Q60
  localparam int SW  = TW + 1;      // sum of two triple products
  localparam int RSH = 61 - OUT_WIDTH;
  localparam int RW  = SW - RSH;

  localparam int IN_DATA_W  = ((3 * ANG_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((4 * OUT_WIDTH + 7) / 8) * 8;

  localparam logic signed [ZW-1:0] ANG_90       = ZW'(5898240);
  localparam logic signed [ZW-1:0] ANG_180      = ZW'(11796480);
  localparam logic signed [XW-1:0] CORDIC_START = XW'(652032874);

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } rot_t;

  typedef struct packed {
    logic signed [XW-1:0] c;
    logic signed [XW-1:0] s;
  } cs_t;

  typedef struct packed {
    cs_t roll;
    cs_t pitch;
    cs_t yaw;
  } trig_t;

  // atan(2^-i) in 2^-16 degree, rounded
  function automatic logic signed [ZW-1:0] atan_unit(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = ZW'(2949120);
      1:  a = ZW'(1740967);
      2:  a = ZW'(919879);
      3:  a = ZW'(466945);
      4:  a = ZW'(234379);
      5:  a = ZW'(117304);
      6:  a = ZW'(58666);
      7:  a = ZW'(29335);
      8:  a = ZW'(14668);
      9:  a = ZW'(7334);
      10: a = ZW'(3667);
      11: a = ZW'(1833);
      12: a = ZW'(917);
      13: a = ZW'(458);
      14: a = ZW'(229);
      15: a = ZW'(115);
      16: a = ZW'(57);
      17: a = ZW'(29);
      18: a = ZW'(14);
      19: a = ZW'(7);
      20: a = ZW'(4);
      21: a = ZW'(2);
      22: a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // half angle (same count, 1/256 degree) to CORDIC start, one fold of 180
  function automatic rot_t rot_load(input logic signed [ANG_W-1:0] ang);
    rot_t r;
    logic signed [ZW-1:0] z;
    z = {ang[ANG_W-1], ang, 8'b0};
    r.x = CORDIC_START;
    r.y = '0;
    r.neg = 1'b0;
    if (z > ANG_90) begin
      z = z - ANG_180;
      r.neg = 1'b1;
    end else if (z < -ANG_90) begin
      z = z + ANG_180;
      r.neg = 1'b1;
    end
    r.z = z;
    return r;
  endfunction

  function automatic rot_t rot_step(input rot_t r, input int i);
    rot_t o;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    dx = r.y >>> i;
    dy = r.x >>> i;
    o.neg = r.neg;
    if (!r.z[ZW-1]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - atan_unit(i);
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + atan_unit(i);
    end
    return o;
  endfunction

endpackage

[hw/rtl/euler_zyx_to_quaternion_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_zyx_to_quaternion_top
// ZYX Euler angles (1/128 degree) to a Q1.15 unit quaternion.
// ----------------------------------------------------------------------------
//  channel | dir | payload (low bit up)
//  in_*    | in  | tdata: roll_angle[16:0], pitch_angle[33:17], yaw_angle[50:34]
//  out_*   | out | tdata: quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
//
//  One request per cycle while the output is not stalled; requests pass through
//  the CORDIC pipeline, one micro-rotation a stage, then the product pipeline.
//  rst_n is synchronous; it clears the valid bits only.
//  Every stage stalls only when full and its successor is stalled, so bubbles
//  collapse and in_tready stays high while any stage downstream is empty.
// ----------------------------------------------------------------------------
module euler_zyx_to_quaternion_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // roll_angle, pitch_angle, yaw_angle (17 bits each), zero pad
  input  logic [ezq_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // quat_w, quat_x, quat_y, quat_z (OUT_WIDTH bits each), zero pad
  output logic [ezq_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import ezq_pkg::*;

  logic                        trig_valid;
  logic                        trig_ready;
  trig_t                       trig;
  logic signed [OUT_WIDTH-1:0] qw, qx, qy, qz;

  ezq_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .roll      ($signed(in_tdata[ANG_W-1:0])),
    .pitch     ($signed(in_tdata[2*ANG_W-1:ANG_W])),
    .yaw       ($signed(in_tdata[3*ANG_W-1:2*ANG_W])),
    .out_valid (trig_valid),
    .out_ready (trig_ready),
    .out_trig  (trig)
  );

  ezq_quat u_quat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (trig_valid),
    .in_ready  (trig_ready),
    .in_trig   (trig),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .quat_w    (qw),
    .quat_x    (qx),
    .quat_y    (qy),
    .quat_z    (qz)
  );

  assign out_tdata = OUT_DATA_W'({qz, qy, qx, qw});

endmodule

[hw/rtl/ezq_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezq_cordic
// Three parallel rotation-mode CORDIC pipelines, one micro-rotation a stage.
// ----------------------------------------------------------------------------
module ezq_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ezq_pkg::ANG_W-1:0]   roll,
  input  logic signed [ezq_pkg::ANG_W-1:0]   pitch,
  input  logic signed [ezq_pkg::ANG_W-1:0]   yaw,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ezq_pkg::trig_t                     out_trig
);
  import ezq_pkg::*;

  localparam int LAST = CORDIC_N + 1;   // stage 0 load, 1..N rotate, LAST sign fix

  logic [LAST:0]   v_r;
  logic [LAST:0]   v_in;
  logic [LAST+1:0] en;
  rot_t            rot_r [0:CORDIC_N][0:2];
  trig_t           trig_r;
  trig_t           trig_nxt;

  assign en[LAST+1] = out_ready;
  assign v_in = {v_r[LAST-1:0], in_valid};

  genvar k, a;
  generate
    for (k = 0; k <= LAST; k++) begin : g_en
      assign en[k] = ~v_r[k] | en[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i <= LAST; i++) begin
        if (en[i]) v_r[i] <= v_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rot_r[0][0] <= rot_load(roll);
      rot_r[0][1] <= rot_load(pitch);
      rot_r[0][2] <= rot_load(yaw);
    end
  end

  generate
    for (k = 1; k <= CORDIC_N; k++) begin : g_rot
      for (a = 0; a < 3; a++) begin : g_ang
        rot_t rot_nxt;
        assign rot_nxt = rot_step(rot_r[k-1][a], k - 1);
        always_ff @(posedge clk) begin
          if (en[k]) rot_r[k][a] <= rot_nxt;
        end
      end
    end
  endgenerate

  always_comb begin
    trig_nxt.roll.c  = rot_r[CORDIC_N][0].neg ? -rot_r[CORDIC_N][0].x : rot_r[CORDIC_N][0].x;
    trig_nxt.roll.s  = rot_r[CORDIC_N][0].neg ? -rot_r[CORDIC_N][0].y : rot_r[CORDIC_N][0].y;
    trig_nxt.pitch.c = rot_r[CORDIC_N][1].neg ? -rot_r[CORDIC_N][1].x : rot_r[CORDIC_N][1].x;
    trig_nxt.pitch.s = rot_r[CORDIC_N][1].neg ? -rot_r[CORDIC_N][1].y : rot_r[CORDIC_N][1].y;
    trig_nxt.yaw.c   = rot_r[CORDIC_N][2].neg ? -rot_r[CORDIC_N][2].x : rot_r[CORDIC_N][2].x;
    trig_nxt.yaw.s   = rot_r[CORDIC_N][2].neg ? -rot_r[CORDIC_N][2].y : rot_r[CORDIC_N][2].y;
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) trig_r <= trig_nxt;
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[LAST];
  assign out_trig  = trig_r;

endmodule

[hw/rtl/ezq_quat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezq_quat
// Product pipeline: pair products, rounding, triple products, sums, output.
// ----------------------------------------------------------------------------
module ezq_quat (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  ezq_pkg::trig_t                        in_trig,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [ezq_pkg::OUT_WIDTH-1:0]  quat_w,
  output logic signed [ezq_pkg::OUT_WIDTH-1:0]  quat_x,
  output logic signed [ezq_pkg::OUT_WIDTH-1:0]  quat_y,
  output logic signed [ezq_pkg::OUT_WIDTH-1:0]  quat_z
);
  import ezq_pkg::*;

  localparam int NST = 5;
  localparam logic signed [PW-1:0] RND29 = PW'(1) << 29;
  localparam logic signed [SW-1:0] RHALF = SW'(1) << (RSH - 1);
  localparam logic signed [RW-1:0] OUT_HI =
    {{(RW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
  localparam logic signed [RW-1:0] OUT_LO =
    {{(RW-OUT_WIDTH+1){1'b1}}, {(OUT_WIDTH-1){1'b0}}};

  logic [NST-1:0] v_r;
  logic [NST-1:0] v_in;
  logic [NST:0]   en;

  // stage 1: yaw/pitch pair products, roll carried along
  logic signed [PW-1:0]  pr_r [0:3];
  logic signed [XW-1:0]  cr1_r, sr1_r;
  // stage 2: pair products rounded to Q30
  logic signed [ABW-1:0] ab_r [0:3];
  logic signed [XW-1:0]  cr2_r, sr2_r;
  // stage 3: triple products
  logic signed [TW-1:0]  t_r [0:7];
  // stage 4: component sums
  logic signed [SW-1:0]  s_r [0:3];
  // stage 5: rounded, saturated outputs
  logic signed [OUT_WIDTH-1:0] q_r   [0:3];
  logic signed [OUT_WIDTH-1:0] q_nxt [0:3];

  assign en[NST] = out_ready;
  assign v_in = {v_r[NST-2:0], in_valid};

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_en
      assign en[k] = ~v_r[k] | en[k+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pr_r[0] <= PW'(in_trig.yaw.c * in_trig.pitch.c);
      pr_r[1] <= PW'(in_trig.yaw.s * in_trig.pitch.s);
      pr_r[2] <= PW'(in_trig.yaw.c * in_trig.pitch.s);
      pr_r[3] <= PW'(in_trig.yaw.s * in_trig.pitch.c);
      cr1_r   <= in_trig.roll.c;
      sr1_r   <= in_trig.roll.s;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 4; i++) begin
        ab_r[i] <= ABW'((pr_r[i] + RND29) >>> 30);
      end
      cr2_r <= cr1_r;
      sr2_r <= sr1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t_r[0] <= TW'(ab_r[0] * cr2_r);  // cy cp cr
      t_r[1] <= TW'(ab_r[1] * sr2_r);  // sy sp sr
      t_r[2] <= TW'(ab_r[0] * sr2_r);  // cy cp sr
      t_r[3] <= TW'(ab_r[1] * cr2_r);  // sy sp cr
      t_r[4] <= TW'(ab_r[2] * cr2_r);  // cy sp cr
      t_r[5] <= TW'(ab_r[3] * sr2_r);  // sy cp sr
      t_r[6] <= TW'(ab_r[3] * cr2_r);  // sy cp cr
      t_r[7] <= TW'(ab_r[2] * sr2_r);  // cy sp sr
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s_r[0] <= SW'(t_r[0]) + SW'(t_r[1]);
      s_r[1] <= SW'(t_r[2]) - SW'(t_r[3]);
      s_r[2] <= SW'(t_r[4]) + SW'(t_r[5]);
      s_r[3] <= SW'(t_r[6]) - SW'(t_r[7]);
    end
  end

  always_comb begin
    logic signed [SW-1:0] rs;
    logic signed [RW-1:0] r;
    for (int i = 0; i < 4; i++) begin
      rs = (s_r[i] + RHALF) >>> RSH;
      r  = $signed(rs[RW-1:0]);
      if (r > OUT_HI)      q_nxt[i] = OUT_HI[OUT_WIDTH-1:0];
      else if (r < OUT_LO) q_nxt[i] = OUT_LO[OUT_WIDTH-1:0];
      else                 q_nxt[i] = r[OUT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 4; i++) q_r[i] <= q_nxt[i];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];
  assign quat_w = q_r[0];
  assign quat_x = q_r[1];
  assign quat_y = q_r[2];
  assign quat_z = q_r[3];

endmodule

[hw/rtl/ezq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ezq_checker
// Port-level assertions for the Euler converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "euler_zyx_to_quaternion_top_defines.svh"

module ezq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [ezq_pkg::IN_DATA_W-1:0]     in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ezq_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import ezq_pkg::*;

  logic unused_in;
  assign unused_in = in_tvalid ^ (^in_tdata);

  `EZQ_AST_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `EZQ_AST_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  // an empty output stage means the whole ready chain is open
  `EZQ_AST_NOW(a_ready_open, clk, rst_n, !out_tvalid, in_tready)
  `EZQ_AST_NEXT_ALL(a_reset_clear, clk, !rst_n, !out_tvalid)

endmodule

bind euler_zyx_to_quaternion_top ezq_checker u_ezq_checker (.*);

[bench/euler_zyx_to_quaternion_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_zyx_to_quaternion_checker
// Watches both channels of the Euler to quaternion block. For every accepted
// request it computes the expected quaternion with its own bit-true CORDIC and
// product pipeline. Each returned quaternion is compared field by field with
// the oldest expected one.
// ----------------------------------------------------------------------------
module euler_zyx_to_quaternion_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // roll_angle, pitch_angle, yaw_angle (17 bits each), zero pad
  input  logic [ezq_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // quat_w, quat_x, quat_y, quat_z (16 bits each), zero pad
  input  logic [ezq_pkg::OUT_DATA_W-1:0]  out_tdata,
  output int                              fail_count,
  output int                              quat_count,
  output int                              pending_count
);
  import ezq_pkg::*;

  localparam int AW = ANG_W;
  localparam int QW = OUT_WIDTH;
  localparam longint QUARTER = 64'sd5898240;    // 90 deg in 2^-16 deg
  localparam longint HALF_TURN = 64'sd11796480;
  localparam longint GAIN_INV = 64'sd652032874; // 0.60725 in Q30

  // packed MSB first, so w lands in the low bits like on the bus
  typedef struct packed {
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] w;
  } quat_t;

  longint atan_deg[32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  quat_t expected_quats[$];

  // cos and sin in Q30 of half the given angle
  function automatic void half_angle_trig(input logic signed [AW-1:0] ang,
                                          output longint c, output longint s);
    longint zr, xr, yr, dx, dy;
    bit flip;
    zr = longint'(ang) * 256;
    xr = GAIN_INV;
    yr = 0;
    flip = 0;
    if (zr > QUARTER) begin
      zr = zr - HALF_TURN;
      flip = 1;
    end else if (zr < -QUARTER) begin
      zr = zr + HALF_TURN;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (zr >= 0) begin
        xr = xr - dx;
        yr = yr + dy;
        zr = zr - atan_deg[i];
      end else begin
        xr = xr + dx;
        yr = yr - dy;
        zr = zr + atan_deg[i];
      end
    end
    c = flip ? -xr : xr;
    s = flip ? -yr : yr;
  endfunction

  function automatic longint prod3(input longint a, input longint b, input longint c);
    longint ab;
    ab = (a * b + (64'sd1 <<< 29)) >>> 30;
    return ab * c;
  endfunction

  function automatic logic signed [QW-1:0] round_sat(input longint v);
    longint r;
    r = (v + (64'sd1 <<< (60 - QW))) >>> (61 - QW);
    if (r > (64'sd1 <<< (QW - 1)) - 1) r = (64'sd1 <<< (QW - 1)) - 1;
    if (r < -(64'sd1 <<< (QW - 1))) r = -(64'sd1 <<< (QW - 1));
    return r[QW-1:0];
  endfunction

  function automatic quat_t euler_to_quat(input logic [IN_DATA_W-1:0] d);
    longint cr, sr, cp, sp, cy, sy;
    quat_t q;
    half_angle_trig(d[AW-1:0], cr, sr);
    half_angle_trig(d[2*AW-1:AW], cp, sp);
    half_angle_trig(d[3*AW-1:2*AW], cy, sy);
    q.w = round_sat(prod3(cy, cp, cr) + prod3(sy, sp, sr));
    q.x = round_sat(prod3(cy, cp, sr) - prod3(sy, sp, cr));
    q.y = round_sat(prod3(cy, sp, cr) + prod3(sy, cp, sr));
    q.z = round_sat(prod3(sy, cp, cr) - prod3(cy, sp, sr));
    return q;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %0s at quaternion %0d: got %0d, expected %0d",
             what, quat_count, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    quat_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    quat_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[4*QW-1:0];
        if (expected_quats.size() == 0) begin
          report("unexpected quaternion w", got.w, 0);
        end else begin
          want = expected_quats.pop_front();
          if (got.w !== want.w) report("quat_w", got.w, want.w);
          if (got.x !== want.x) report("quat_x", got.x, want.x);
          if (got.y !== want.y) report("quat_y", got.y, want.y);
          if (got.z !== want.z) report("quat_z", got.z, want.z);
        end
        quat_count++;
      end
      if (in_tvalid && in_tready) expected_quats.push_back(euler_to_quat(in_tdata));
      pending_count = expected_quats.size();
    end
  end

endmodule

[bench/tb_euler_zyx_to_quaternion_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_zyx_to_quaternion_top
// Drives directed and random Euler angle requests into the converter with
// random gaps on input and back-pressure on output; the checker predicts and
// compares every quaternion.
// ----------------------------------------------------------------------------
module tb_euler_zyx_to_quaternion_top;
  import ezq_pkg::*;

  localparam int N_RANDOM = 550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LATENCY = 23;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  int                     fail_count;
  int                     quat_count;
  int                     pending_count;
  int                     cycles;
  int                     sent;
  bit                     no_idle;

  euler_zyx_to_quaternion_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  euler_zyx_to_quaternion_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .quat_count(quat_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    cycles = 0;
    sent = 0;
    no_idle = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sink back-pressure, none while the long burst runs
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= no_idle || ($urandom_range(0, 99) >= 20);
  end

  function automatic logic [ANG_W-1:0] rand_angle();
    int v;
    if ($urandom_range(0, 9) < 7) begin
      v = $urandom_range(0, 92160);
      return ANG_W'(v - 46080);
    end
    return ANG_W'($urandom);
  endfunction

  // present one request, hold until accepted, then maybe leave a gap
  task automatic send_angles(input logic [ANG_W-1:0] r, input logic [ANG_W-1:0] p,
                             input logic [ANG_W-1:0] y);
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_DATA_W - 3 * ANG_W){1'b0}}, y, p, r};
    do @(posedge clk); while (!in_tready);
    sent++;
    if (!no_idle && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  initial begin
    logic [ANG_W-1:0] edges[12];
    edges = '{17'd0, 17'd46080, -17'sd46080, 17'd11520, -17'sd11520, 17'd23040,
              -17'sd23040, 17'd65535, 17'h10000, 17'd1, 17'h1FFFF, 17'd34560};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, quarter and half turns, fold boundaries, out-of-range patterns
    for (int i = 0; i < 12; i++) send_angles(edges[i], edges[(i + 3) % 12], edges[(i + 7) % 12]);
    for (int i = 0; i < 12; i += 3) send_angles(edges[i], edges[i], edges[i]);
    send_angles(17'd0, 17'd11520, 17'd0);   // gimbal lock, pitch +90
    send_angles(17'd0, -17'sd11520, 17'd0);

    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle = (n >= 250 && n < 400);
      send_angles(rand_angle(), rand_angle(), rand_angle());
    end
    no_idle = 0;
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    $display("Converted %0d angle triples (directed extremes, folds, random)", sent);
    $display("Checked %0d quaternions under random gaps and back-pressure", quat_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
